// File: hw/rtl/pra_pkg.sv
// ----------------------------------------------------------------------------
// Page allocator package
// Shared types and fixed field widths of the reference counting page
// allocator.
// ----------------------------------------------------------------------------
package pra_pkg;

  // Fixed widths of the transaction fields.
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned REF_OUT_W  = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 1'b1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_GET   = 2'd3
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BADADDR   = 3'd1,
    ST_FREEUNREF = 3'd2,
    ST_GETFREE   = 3'd3,
    ST_OOM       = 3'd4,
    ST_SAT       = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_INIT_BASE,
    S_INIT_SIZE,
    S_INIT_FILL,
    S_INIT_DONE
  } state_e;

endpackage

// File: hw/rtl/pra_if.sv
// ----------------------------------------------------------------------------
// Page allocator channels
// Valid/ready channels for the command and response transactions.
// ----------------------------------------------------------------------------
interface pra_in_if;
  logic                          valid;
  logic                          ready;
  logic [pra_pkg::OPCODE_W-1:0]  opcode;
  logic [pra_pkg::ADDR_W-1:0]    address;

  modport source (output valid, output opcode, output address, input ready);
  modport sink   (input valid, input opcode, input address, output ready);
endinterface

interface pra_out_if;
  logic                          valid;
  logic                          ready;
  logic [pra_pkg::STATUS_W-1:0]  status;
  logic [pra_pkg::ADDR_W-1:0]    page_address;
  logic [pra_pkg::REF_OUT_W-1:0] ref_after;

  modport source (output valid, output status, output page_address, output ref_after,
                  input ready);
  modport sink   (input valid, input status, input page_address, input ref_after,
                  output ready);
endinterface

// File: hw/rtl/pra_ram.sv
// ----------------------------------------------------------------------------
// Page allocator RAM
// Simple dual-port synchronous RAM with one write port and one registered
// read port.
// ----------------------------------------------------------------------------
module pra_ram #(
  parameter int unsigned DEPTH = 32768,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/pra_ctrl.sv
// ----------------------------------------------------------------------------
// Page allocator controller
// Sequencer that checks commands, reads the stack and count memories,
// modifies and writes them back, and runs the init fill sweep.
// ----------------------------------------------------------------------------
module pra_ctrl #(
  parameter int unsigned MAX_PAGES  = 32768,
  parameter int unsigned PAGE_BYTES = 4096,
  parameter int unsigned REF_BITS   = 8,
  localparam int unsigned IDX_W     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [pra_pkg::ADDR_W-1:0]  region_start_i,
  input  logic [pra_pkg::ADDR_W-1:0]  region_end_i,
  pra_in_if.sink                      in_i,
  pra_out_if.source                   out_o,
  // Free stack memory.
  output logic                        stk_we_o,
  output logic [IDX_W-1:0]            stk_waddr_o,
  output logic [IDX_W-1:0]            stk_wdata_o,
  output logic                        stk_re_o,
  output logic [IDX_W-1:0]            stk_raddr_o,
  input  logic [IDX_W-1:0]            stk_rdata_i,
  // Reference count memory.
  output logic                        ref_we_o,
  output logic [IDX_W-1:0]            ref_waddr_o,
  output logic [REF_BITS-1:0]         ref_wdata_o,
  output logic                        ref_re_o,
  output logic [IDX_W-1:0]            ref_raddr_o,
  input  logic [REF_BITS-1:0]         ref_rdata_i
);
  import pra_pkg::*;

  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned CNT_W      = $clog2(MAX_PAGES + 1);
  localparam int unsigned PG_W       = ADDR_W - PAGE_SHIFT;
  localparam int unsigned CMP_W      = (PG_W > CNT_W) ? PG_W : CNT_W;
  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
  localparam logic [REF_BITS-1:0] REF_ONE = REF_BITS'(1);
  localparam logic [CNT_W-1:0]    CNT_MAX = CNT_W'(MAX_PAGES);

  state_e                   state_q, state_d;
  opcode_e                  op_q, op_d;
  logic                     bad_q, bad_d;
  logic                     oom_q, oom_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic [CNT_W-1:0]         fc_q, fc_d;
  logic [CNT_W-1:0]         cursor_q, cursor_d;
  logic [ADDR_W-1:0]        base_q, base_d;
  logic                     base_ok_q, base_ok_d;
  logic [CNT_W-1:0]         pages_q, pages_d;
  logic                     out_valid_q, out_valid_d;
  status_e                  out_status_q, out_status_d;
  logic [ADDR_W-1:0]        out_paddr_q, out_paddr_d;
  logic [REF_OUT_W-1:0]     out_ref_q, out_ref_d;

  logic                     accept;
  logic                     slot_free;
  logic                     exec_fire;
  logic                     done_fire;
  logic                     fill_end;
  opcode_e                  in_op;
  logic                     aligned;
  logic                     above_base;
  logic [ADDR_W-1:0]        offset;
  logic [PG_W-1:0]          pg;
  logic                     in_window;
  logic                     addr_bad;
  logic [ADDR_W:0]          start_round;
  logic [PG_W-1:0]          raw_pages;
  logic [REF_BITS-1:0]      cnt_dec;
  logic [REF_BITS-1:0]      cnt_inc;

  // Handshake and command decode.
  assign in_op     = opcode_e'(in_i.opcode);
  assign accept    = in_i.valid && in_i.ready;
  assign slot_free = !out_valid_q || out_o.ready;
  assign exec_fire = (state_q == S_EXEC) && slot_free;
  assign done_fire = (state_q == S_INIT_DONE) && slot_free;
  assign fill_end  = (cursor_q == pages_q);

  // Page address check against the window latched at the last init.
  assign aligned    = (in_i.address[PAGE_SHIFT-1:0] == '0);
  assign above_base = (in_i.address >= base_q);
  assign offset     = in_i.address - base_q;
  assign pg         = offset[ADDR_W-1:PAGE_SHIFT];
  assign in_window  = (CMP_W'(pg) < CMP_W'(pages_q));
  assign addr_bad   = !(aligned && above_base && in_window);

  // Window size arithmetic for init.
  assign start_round = {1'b0, region_start_i} + (ADDR_W + 1)'(PAGE_BYTES - 1);
  assign raw_pages   = PG_W'((region_end_i - base_q) >> PAGE_SHIFT);

  assign cnt_dec = ref_rdata_i - REF_ONE;
  assign cnt_inc = ref_rdata_i + REF_ONE;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (in_op == OP_INIT) ? S_INIT_BASE : S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_d = S_IDLE;
        end
      end
      S_INIT_BASE: state_d = S_INIT_SIZE;
      S_INIT_SIZE: state_d = S_INIT_FILL;
      S_INIT_FILL: begin
        if (fill_end) begin
          state_d = S_INIT_DONE;
        end
      end
      S_INIT_DONE: begin
        if (done_fire) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Memory accesses, window registers and results.
  always_comb begin
    in_i.ready   = (state_q == S_IDLE);
    op_d         = op_q;
    bad_d        = bad_q;
    oom_d        = oom_q;
    idx_d        = idx_q;
    fc_d         = fc_q;
    cursor_d     = cursor_q;
    base_d       = base_q;
    base_ok_d    = base_ok_q;
    pages_d      = pages_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_paddr_d  = out_paddr_q;
    out_ref_d    = out_ref_q;
    stk_we_o     = 1'b0;
    stk_waddr_o  = IDX_W'(fc_q);
    stk_wdata_o  = idx_q;
    stk_re_o     = 1'b0;
    stk_raddr_o  = IDX_W'(fc_q - 1'b1);
    ref_we_o     = 1'b0;
    ref_waddr_o  = idx_q;
    ref_wdata_o  = '0;
    ref_re_o     = 1'b0;
    ref_raddr_o  = IDX_W'(pg);

    case (state_q)
      // Capture the command and start the memory read.
      S_IDLE: begin
        if (accept) begin
          op_d     = in_op;
          bad_d    = addr_bad;
          oom_d    = (fc_q == '0);
          idx_d    = IDX_W'(pg);
          stk_re_o = (in_op == OP_ALLOC);
          ref_re_o = ((in_op == OP_FREE) || (in_op == OP_GET)) && !addr_bad;
        end
      end
      // Read data is here: modify, write back and post the result.
      S_EXEC: begin
        if (exec_fire) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_OK;
          out_paddr_d  = '0;
          out_ref_d    = '0;
          case (op_q)
            OP_ALLOC: begin
              if (oom_q) begin
                out_status_d = ST_OOM;
              end else begin
                fc_d        = fc_q - 1'b1;
                ref_we_o    = 1'b1;
                ref_waddr_o = stk_rdata_i;
                ref_wdata_o = REF_ONE;
                out_ref_d   = REF_OUT_W'(REF_ONE);
                out_paddr_d = base_q + (ADDR_W'(stk_rdata_i) << PAGE_SHIFT);
              end
            end
            OP_FREE: begin
              if (bad_q) begin
                out_status_d = ST_BADADDR;
              end else if (ref_rdata_i == '0) begin
                out_status_d = ST_FREEUNREF;
              end else begin
                ref_we_o    = 1'b1;
                ref_wdata_o = cnt_dec;
                out_ref_d   = REF_OUT_W'(cnt_dec);
                if ((cnt_dec == '0) && (fc_q < CNT_MAX)) begin
                  stk_we_o = 1'b1;
                  fc_d     = fc_q + 1'b1;
                end
              end
            end
            OP_GET: begin
              if (bad_q) begin
                out_status_d = ST_BADADDR;
              end else if (ref_rdata_i == '0) begin
                out_status_d = ST_GETFREE;
              end else if (ref_rdata_i == REF_MAX) begin
                out_status_d = ST_SAT;
                out_ref_d    = REF_OUT_W'(ref_rdata_i);
              end else begin
                ref_we_o    = 1'b1;
                ref_wdata_o = cnt_inc;
                out_ref_d   = REF_OUT_W'(cnt_inc);
              end
            end
            default: begin
              out_status_d = ST_OK;
            end
          endcase
        end
      end
      // Round the start address up to a page.
      S_INIT_BASE: begin
        base_d    = {start_round[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
        base_ok_d = !start_round[ADDR_W];
      end
      // Count whole pages and cut to the memory depth.
      S_INIT_SIZE: begin
        cursor_d = '0;
        if (!base_ok_q || (region_end_i <= base_q)) begin
          pages_d = '0;
        end else if (CMP_W'(raw_pages) > CMP_W'(CNT_MAX)) begin
          pages_d = CNT_MAX;
        end else begin
          pages_d = CNT_W'(raw_pages);
        end
      end
      // Clear one count and push one page per cycle, lowest first.
      S_INIT_FILL: begin
        if (!fill_end) begin
          stk_we_o    = 1'b1;
          stk_waddr_o = IDX_W'(cursor_q);
          stk_wdata_o = IDX_W'(cursor_q);
          ref_we_o    = 1'b1;
          ref_waddr_o = IDX_W'(cursor_q);
          ref_wdata_o = '0;
          cursor_d    = cursor_q + 1'b1;
        end
      end
      S_INIT_DONE: begin
        if (done_fire) begin
          fc_d         = pages_q;
          out_valid_d  = 1'b1;
          out_status_d = ST_OK;
          out_paddr_d  = '0;
          out_ref_d    = '0;
        end
      end
      default: begin
        out_valid_d = out_valid_q && !out_o.ready;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fc_q        <= '0;
      cursor_q    <= '0;
      base_q      <= '0;
      base_ok_q   <= 1'b1;
      pages_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fc_q        <= fc_d;
      cursor_q    <= cursor_d;
      base_q      <= base_d;
      base_ok_q   <= base_ok_d;
      pages_q     <= pages_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    bad_q        <= bad_d;
    oom_q        <= oom_d;
    idx_q        <= idx_d;
    out_status_q <= out_status_d;
    out_paddr_q  <= out_paddr_d;
    out_ref_q    <= out_ref_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.page_address = out_paddr_q;
  assign out_o.ref_after    = out_ref_q;

endmodule

// File: hw/rtl/page_allocator_refcount_top.sv
// ----------------------------------------------------------------------------
// Page allocator with reference counts
// Free page stack and per page counts in two RAMs, configured window.
// ----------------------------------------------------------------------------
// Allocate, free and add reference accept and start the RAM read in S_IDLE,
// then modify, write back and register the response in S_EXEC, which waits
// for a free response slot. Init steps S_INIT_BASE, S_INIT_SIZE, S_INIT_FILL
// (one page per cycle) and S_INIT_DONE. A new command is taken while a
// response waits. Reset clears control state only; the RAMs hold garbage
// and the window is empty until the first init.
module page_allocator_refcount_top #(
  parameter int unsigned MAX_PAGES  = 32768,
  parameter int unsigned PAGE_BYTES = 4096,
  parameter int unsigned REF_BITS   = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pra_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pra_pkg::CFG_DATA_W-1:0] cfg_data_i,
  pra_in_if.sink                         in_i,
  pra_out_if.source                      out_o
);
  import pra_pkg::*;

  localparam int unsigned IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

  logic [ADDR_W-1:0]   region_start_q;
  logic [ADDR_W-1:0]   region_end_q;
  logic                stk_we;
  logic [IDX_W-1:0]    stk_waddr;
  logic [IDX_W-1:0]    stk_wdata;
  logic                stk_re;
  logic [IDX_W-1:0]    stk_raddr;
  logic [IDX_W-1:0]    stk_rdata;
  logic                ref_we;
  logic [IDX_W-1:0]    ref_waddr;
  logic [REF_BITS-1:0] ref_wdata;
  logic                ref_re;
  logic [IDX_W-1:0]    ref_raddr;
  logic [REF_BITS-1:0] ref_rdata;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_start_q <= '0;
      region_end_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_REGION_START: region_start_q <= ADDR_W'(cfg_data_i);
        CFG_REGION_END:   region_end_q   <= ADDR_W'(cfg_data_i);
        default:          region_end_q   <= region_end_q;
      endcase
    end
  end

  pra_ctrl #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES),
    .REF_BITS   (REF_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .region_start_i (region_start_q),
    .region_end_i   (region_end_q),
    .in_i           (in_i),
    .out_o          (out_o),
    .stk_we_o       (stk_we),
    .stk_waddr_o    (stk_waddr),
    .stk_wdata_o    (stk_wdata),
    .stk_re_o       (stk_re),
    .stk_raddr_o    (stk_raddr),
    .stk_rdata_i    (stk_rdata),
    .ref_we_o       (ref_we),
    .ref_waddr_o    (ref_waddr),
    .ref_wdata_o    (ref_wdata),
    .ref_re_o       (ref_re),
    .ref_raddr_o    (ref_raddr),
    .ref_rdata_i    (ref_rdata)
  );

  // Free page stack.
  pra_ram #(
    .DEPTH (MAX_PAGES),
    .WIDTH (IDX_W)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // Reference counts.
  pra_ram #(
    .DEPTH (MAX_PAGES),
    .WIDTH (REF_BITS)
  ) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (ref_we),
    .waddr_i (ref_waddr),
    .wdata_i (ref_wdata),
    .re_i    (ref_re),
    .raddr_i (ref_raddr),
    .rdata_o (ref_rdata)
  );

endmodule

// File: hw/rtl/pra_chk.sv
// ----------------------------------------------------------------------------
// Page allocator checker
// Concurrent assertions on the response port of the allocator.
// ----------------------------------------------------------------------------
module pra_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [pra_pkg::STATUS_W-1:0]  out_status_i,
  input logic [pra_pkg::ADDR_W-1:0]    out_page_address_i,
  input logic [pra_pkg::REF_OUT_W-1:0] out_ref_after_i
);
  import pra_pkg::*;

  // A stalled response stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("response dropped while stalled");

  // Only defined status codes leave the block.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_status_i <= ST_SAT))
    else $error("undefined status code");

  // A page address only comes with a successful allocation.
  a_paddr_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_page_address_i != '0) |->
      (out_status_i == ST_OK) && (out_ref_after_i == REF_OUT_W'(1)))
    else $error("page address without a fresh allocation");

  // Failed commands report no address.
  a_fail_no_paddr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != ST_OK) |-> (out_page_address_i == '0))
    else $error("page address on a failed command");

  // Rejected commands other than a saturated add report a zero count.
  a_fail_no_ref: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((out_status_i == ST_OOM) || (out_status_i == ST_BADADDR) ||
                    (out_status_i == ST_FREEUNREF) || (out_status_i == ST_GETFREE))
      |-> (out_ref_after_i == '0))
    else $error("nonzero count on a rejected command");

endmodule

bind page_allocator_refcount_top pra_chk u_pra_chk (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_status_i       (out_o.status),
  .out_page_address_i (out_o.page_address),
  .out_ref_after_i    (out_o.ref_after)
);
